// ===== design/mhpq_pkg.sv =====
`timescale 1ns / 1ps

package mhpq_pkg;

    localparam int KEY_W   = 32;
    localparam int COUNT_W = 11;

    typedef logic signed [KEY_W-1:0] key_t;
    typedef logic [1:0]              status_t;

    // command codes
    localparam logic CMD_INSERT  = 1'b0;
    localparam logic CMD_EXTRACT = 1'b1;

    // result status codes
    localparam status_t ST_OK    = 2'd0;
    localparam status_t ST_FULL  = 2'd1;
    localparam status_t ST_EMPTY = 2'd2;

endpackage

// ===== design/max_heap_priority_queue.sv =====
`timescale 1ns / 1ps

// Binary max-heap priority queue holding up to CAPACITY signed 32-bit keys in
// one synchronous memory (one write port, two read ports, registered read
// data). A request word is either an insert (cmd 0) of key or an extract of
// the largest key (cmd 1); every request gives exactly one response word with
// max_key (0 unless an extract succeeded), status (0 ok, 1 full, 2 empty) and
// count, the number of keys held afterwards. A full or empty error leaves the
// heap untouched. One request is worked on at a time. The sift loop does one
// heap level per cycle (read the parent or both children, compare, write back
// one entry). An extract first loads the root and the last key together. When
// the sift ends, the response goes through S_DONE into the output register; an
// error response goes to S_DONE straight from acceptance. A finished response
// waits in the output register, so the next request is taken while the previous
// response is still stalled.
module max_heap_priority_queue
    import mhpq_pkg::*;
#(
    parameter int CAPACITY = 1024
)
(
    input  logic                clk,
    input  logic                rst_n,
    // request channel
    input  logic                req_valid,
    output logic                req_stall,
    input  logic                cmd,
    input  logic signed [31:0]  key,
    // response channel
    output logic                rsp_valid,
    input  logic                rsp_stall,
    output logic signed [31:0]  max_key,
    output logic [1:0]          status,
    output logic [10:0]         count
);

    // heap positions run 1..CAPACITY; memory address is position - 1
    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [CW-1:0] CAP_CNT = CW'(CAPACITY);
    localparam logic [CW-1:0] POS_ONE = CW'(1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_UP_CMP,
        S_DN_LOAD,
        S_DN_CMP,
        S_FIN,
        S_DONE
    } state_t;

    state_t          state_reg, state_next;
    logic [CW-1:0]   count_reg, count_next;   // keys held
    logic [CW-1:0]   pos_reg, pos_next;       // current hole position
    key_t            key_reg, key_next;       // key being sifted
    key_t            res_key_reg, res_key_next;
    status_t         res_status_reg, res_status_next;

    logic            rsp_valid_reg;
    key_t            max_key_reg;
    status_t         status_reg;
    logic [10:0]     count_out_reg;

    // memory port signals
    logic            wr_en;
    logic [AW-1:0]   wr_addr;
    key_t            wr_data;
    logic [AW-1:0]   rd_addr_a;
    logic [AW-1:0]   rd_addr_b;
    key_t            rd_data_a;
    key_t            rd_data_b;

    // sift-down compare terms
    logic [CW:0]     left_pos;
    logic [CW:0]     right_pos;
    logic [CW:0]     size_ext;
    logic            take_l;
    logic            take_r;
    key_t            cand;
    logic [CW-1:0]   child_pos;
    key_t            child_val;
    logic [CW:0]     next_left;
    logic [CW-1:0]   parent_pos;

    function automatic logic [AW-1:0] to_addr(input logic [CW:0] p);
        logic [CW:0] a;
        a = p - (CW+1)'(1);
        return a[AW-1:0];
    endfunction

    mhpq_mem #(
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_mem (
        .clk       (clk),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_addr_a (rd_addr_a),
        .rd_addr_b (rd_addr_b),
        .rd_data_a (rd_data_a),
        .rd_data_b (rd_data_b)
    );

    // children of the hole and the larger of them against the sifted key;
    // a key only moves past a strictly smaller one, left wins a tie
    assign left_pos  = {pos_reg, 1'b0};
    assign right_pos = {pos_reg, 1'b1};
    assign size_ext  = {1'b0, count_reg};
    assign take_l    = (left_pos <= size_ext) && (rd_data_a > key_reg);
    assign cand      = take_l ? rd_data_a : key_reg;
    assign take_r    = (right_pos <= size_ext) && (rd_data_b > cand);
    assign child_pos = take_r ? right_pos[CW-1:0] : left_pos[CW-1:0];
    assign child_val = take_r ? rd_data_b : rd_data_a;
    assign next_left = {child_pos, 1'b0};
    assign parent_pos = pos_reg >> 1;

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        pos_next        = pos_reg;
        key_next        = key_reg;
        res_key_next    = res_key_reg;
        res_status_next = res_status_reg;
        wr_en           = 1'b0;
        wr_addr         = to_addr({1'b0, pos_reg});
        wr_data         = key_reg;
        rd_addr_a       = '0;
        rd_addr_b       = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    res_key_next    = '0;
                    res_status_next = ST_OK;
                    if (cmd == CMD_INSERT)
                    begin
                        if (count_reg == CAP_CNT)
                        begin
                            res_status_next = ST_FULL;
                            state_next      = S_DONE;
                        end
                        else
                        begin
                            count_next = count_reg + POS_ONE;
                            pos_next   = count_reg + POS_ONE;
                            key_next   = key;
                            if (count_reg == '0)
                            begin
                                // first key goes straight to the root
                                wr_en      = 1'b1;
                                wr_addr    = '0;
                                wr_data    = key;
                                state_next = S_DONE;
                            end
                            else
                            begin
                                rd_addr_a  = to_addr({1'b0, (count_reg + POS_ONE) >> 1});
                                state_next = S_UP_CMP;
                            end
                        end
                    end
                    else
                    begin
                        if (count_reg == '0)
                        begin
                            res_status_next = ST_EMPTY;
                            state_next      = S_DONE;
                        end
                        else
                        begin
                            // fetch root and last key together
                            rd_addr_a  = '0;
                            rd_addr_b  = to_addr({1'b0, count_reg});
                            count_next = count_reg - POS_ONE;
                            state_next = S_DN_LOAD;
                        end
                    end
                end
            end

            S_UP_CMP:
            begin
                wr_en = 1'b1;
                if (rd_data_a < key_reg)
                begin
                    // parent moves down into the hole
                    wr_data  = rd_data_a;
                    pos_next = parent_pos;
                    if (parent_pos == POS_ONE)
                    begin
                        state_next = S_FIN;
                    end
                    else
                    begin
                        rd_addr_a = to_addr({1'b0, parent_pos >> 1});
                    end
                end
                else
                begin
                    state_next = S_DONE;
                end
            end

            S_DN_LOAD:
            begin
                res_key_next = rd_data_a;
                key_next     = rd_data_b;
                pos_next     = POS_ONE;
                if (count_reg == '0)
                begin
                    state_next = S_DONE;
                end
                else if (count_reg == POS_ONE)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    rd_addr_a  = to_addr((CW+1)'(2));
                    rd_addr_b  = to_addr((CW+1)'(3));
                    state_next = S_DN_CMP;
                end
            end

            S_DN_CMP:
            begin
                wr_en = 1'b1;
                if (take_l || take_r)
                begin
                    // larger child moves up into the hole
                    wr_data  = child_val;
                    pos_next = child_pos;
                    if (next_left > size_ext)
                    begin
                        state_next = S_FIN;
                    end
                    else
                    begin
                        rd_addr_a = to_addr(next_left);
                        rd_addr_b = to_addr(next_left | (CW+1)'(1));
                    end
                end
                else
                begin
                    state_next = S_DONE;
                end
            end

            S_FIN:
            begin
                wr_en      = 1'b1;
                state_next = S_DONE;
            end

            S_DONE:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (state_reg == S_DONE && (!rsp_valid_reg || !rsp_stall))
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg        <= pos_next;
        key_reg        <= key_next;
        res_key_reg    <= res_key_next;
        res_status_reg <= res_status_next;
        if (state_reg == S_DONE && (!rsp_valid_reg || !rsp_stall))
        begin
            max_key_reg   <= res_key_reg;
            status_reg    <= res_status_reg;
            count_out_reg <= 11'(count_reg);
        end
    end

    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign max_key   = max_key_reg;
    assign status    = status_reg;
    assign count     = count_out_reg;

endmodule

// ===== design/mhpq_mem.sv =====
`timescale 1ns / 1ps

// Heap storage: one write port, two read ports, registered read data.
module mhpq_mem
    import mhpq_pkg::*;
#(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
)
(
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  key_t          wr_data,
    input  logic [AW-1:0] rd_addr_a,
    input  logic [AW-1:0] rd_addr_b,
    output key_t          rd_data_a,
    output key_t          rd_data_b
);

    key_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_a <= mem[rd_addr_a];
        rd_data_b <= mem[rd_addr_b];
    end

endmodule

// ===== design/mhpq_check.sv =====
`timescale 1ns / 1ps

module mhpq_check
    import mhpq_pkg::*;
#(
    parameter int CAPACITY = 1024
)
(
    input logic               clk,
    input logic               rst_n,
    input logic               req_valid,
    input logic               req_stall,
    input logic               rsp_valid,
    input logic               rsp_stall,
    input logic signed [31:0] max_key,
    input logic [1:0]         status,
    input logic [10:0]        count
);

    localparam logic [10:0] FULL_CNT = 11'(CAPACITY);

    // a stalled response word holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(max_key)
            && $stable(status) && $stable(count))
        else $error("response changed while stalled");

    // one request at a time: block is busy right after taking a word
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> req_stall)
        else $error("request taken while previous one in flight");

    a_err_key_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && status != ST_OK |-> max_key == '0)
        else $error("error response carries a nonzero key");

    a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && status == ST_EMPTY |-> count == '0)
        else $error("empty status with nonzero count");

    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && status == ST_FULL |-> count == FULL_CNT)
        else $error("full status with count below capacity");

endmodule

bind max_heap_priority_queue mhpq_check #(.CAPACITY(CAPACITY)) u_mhpq_check (.*);

// ===== bench/tb_max_heap_priority_queue.sv =====
`timescale 1ns / 1ps

module tb_max_heap_priority_queue;
    import mhpq_pkg::*;

    localparam int CAPACITY        = 1024;
    // Longest legal stretch with no word moving on either side is the
    // response hold-off below plus one request's sift time.
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int WATCHDOG_LIMIT  = 5000;
    localparam int MAX_GAP         = 40;
    // Quiet time after the last response, long enough to catch any stray word.
    localparam int TAIL_CYCLES     = 40;

    // one expected response word
    typedef struct {
        key_t                 max_key;
        status_t              status;
        logic [COUNT_W-1:0]   count;
    } rsp_word_t;

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               req_valid = 1'b0;
    logic               req_stall;
    logic               cmd       = CMD_INSERT;
    key_t               key       = '0;
    logic               rsp_valid;
    logic               rsp_stall = 1'b0;
    key_t               max_key;
    status_t            status;
    logic [COUNT_W-1:0] count;

    // Predictor state: heap positions 1..CAPACITY, same ordering rules as
    // the block (strictly-greater moves, left child wins a tie).
    key_t               heap_mem [1:CAPACITY];
    int unsigned        heap_size = 0;
    rsp_word_t          pending_rsp_q [$];
    rsp_word_t          want_rsp;

    int                 mismatches    = 0;
    int                 quiet_cycles  = 0;
    int                 send_idle_pct = 0;   // chance the sender idles a cycle
    int                 rsp_stall_pct = 0;   // chance the receiver stalls a cycle
    logic               rsp_held      = 1'b0;
    event               hold_off_ev;

    max_heap_priority_queue #(
        .CAPACITY (CAPACITY)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .cmd       (cmd),
        .key       (key),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .max_key   (max_key),
        .status    (status),
        .count     (count)
    );

    // 12 ns clock
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor: apply one request word to the heap copy and return the
    // response it must produce. Errors leave the heap untouched.
    // ------------------------------------------------------------------
    function automatic rsp_word_t heap_apply(logic op, key_t k);
        rsp_word_t   r;
        int unsigned pos;
        int unsigned best;
        int unsigned lc;
        key_t        tmp;
        r.max_key = '0;
        r.status  = ST_OK;
        if (op == CMD_INSERT)
        begin
            if (heap_size >= CAPACITY)
                r.status = ST_FULL;
            else
            begin
                // append, then sift up past strictly smaller parents
                heap_size++;
                heap_mem[heap_size] = k;
                pos = heap_size;
                while (pos > 1 && heap_mem[pos] > heap_mem[pos / 2])
                begin
                    tmp                = heap_mem[pos];
                    heap_mem[pos]      = heap_mem[pos / 2];
                    heap_mem[pos / 2]  = tmp;
                    pos                = pos / 2;
                end
            end
        end
        else if (heap_size == 0)
            r.status = ST_EMPTY;
        else
        begin
            // take the root, move the last key up, sift it down
            r.max_key           = heap_mem[1];
            heap_mem[1]         = heap_mem[heap_size];
            heap_mem[heap_size] = '0;
            heap_size--;
            pos = 1;
            while (1)
            begin
                best = pos;
                lc   = 2 * pos;
                if (lc <= heap_size && heap_mem[lc] > heap_mem[best])
                    best = lc;
                if (lc + 1 <= heap_size && heap_mem[lc + 1] > heap_mem[best])
                    best = lc + 1;
                if (best == pos)
                    break;
                tmp            = heap_mem[best];
                heap_mem[best] = heap_mem[pos];
                heap_mem[pos]  = tmp;
                pos            = best;
            end
        end
        r.count = COUNT_W'(heap_size);
        return r;
    endfunction

    // Keys lean on the extremes and a narrow band around zero so that
    // duplicates and ties show up often.
    function automatic key_t pick_key();
        case ($urandom_range(9))
            0:       return key_t'(32'h7FFF_FFFF);
            1:       return key_t'(32'h8000_0000);
            2:       return $urandom_range(1) ? key_t'(0) : key_t'(-1);
            3, 4, 5: return key_t'(int'($urandom_range(16)) - 8);
            default: return key_t'($urandom);
        endcase
    endfunction

    task automatic report_mismatch(input string msg);
        mismatches++;
        $display("MISMATCH at %0t ns: %s", $realtime, msg);
    endtask

    // ------------------------------------------------------------------
    // Request driver: optional idle gap, then hold the word until taken.
    // Valid stays high straight into the next word when there is no gap.
    // ------------------------------------------------------------------
    task automatic send_word(input logic op, input key_t k);
        int gap;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(99) < send_idle_pct)
            gap++;
        repeat (gap)
        begin
            @(negedge clk);
            req_valid <= 1'b0;
        end
        @(negedge clk);
        req_valid <= 1'b1;
        cmd       <= op;
        key       <= k;
        do
            @(posedge clk);
        while (req_stall);
        pending_rsp_q.push_back(heap_apply(op, k));
    endtask

    task automatic idle_sender();
        @(negedge clk);
        req_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        idle_sender();
        while (pending_rsp_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic run_mix(input int n_words, input int insert_pct);
        logic op;
        repeat (n_words)
        begin
            op = ($urandom_range(99) < insert_pct) ? CMD_INSERT : CMD_EXTRACT;
            send_word(op, (op == CMD_INSERT) ? pick_key() : key_t'($urandom));
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Extremes, ties and the empty-queue error, back to back.
    task automatic test_directed();
        send_idle_pct = 0;
        rsp_stall_pct = 0;
        send_word(CMD_EXTRACT, key_t'($urandom));      // empty queue
        send_word(CMD_INSERT, key_t'(32'h7FFF_FFFF));
        send_word(CMD_INSERT, key_t'(32'h8000_0000));
        send_word(CMD_INSERT, key_t'(0));
        send_word(CMD_INSERT, key_t'(-1));
        send_word(CMD_INSERT, key_t'(5));
        send_word(CMD_INSERT, key_t'(5));
        send_word(CMD_INSERT, key_t'(5));
        send_word(CMD_INSERT, key_t'(32'h7FFF_FFFF));  // duplicate of max
        repeat (9)
            send_word(CMD_EXTRACT, key_t'($urandom));  // last one hits empty
        send_word(CMD_INSERT, key_t'(1));
        send_word(CMD_EXTRACT, key_t'(32'hFFFF_FFFF));
        wait_drained();
    endtask

    task automatic test_no_idle();
        send_idle_pct = 0;
        rsp_stall_pct = 0;
        run_mix(200, 50);
        wait_drained();
    endtask

    task automatic test_sender_idle();
        send_idle_pct = 75;
        rsp_stall_pct = 0;
        run_mix(200, 50);
        wait_drained();
    endtask

    // Receiver goes dark while requests keep coming: the output register
    // fills, the block takes one more word and then stalls its input.
    task automatic test_backpressure();
        send_idle_pct = 0;
        rsp_stall_pct = 0;
        @(posedge clk);
        -> hold_off_ev;
        run_mix(12, 60);
        // sender pauses until everything is back
        wait_drained();
        run_mix(10, 50);
        wait_drained();
    endtask

    // Mostly inserts until the heap is full, then poke at the full error.
    task automatic test_fill_to_capacity();
        send_idle_pct = 0;
        rsp_stall_pct = 75;
        while (heap_size < CAPACITY)
            run_mix(1, 97);
        run_mix(30, 85);
        wait_drained();
    endtask

    task automatic test_both_idle();
        send_idle_pct = 22;
        rsp_stall_pct = 22;
        run_mix(250, 45);
        wait_drained();
    endtask

    // ------------------------------------------------------------------
    // Receiver side: random stall, forced high during a hold-off.
    // ------------------------------------------------------------------
    always @(negedge clk)
        rsp_stall <= rsp_held || ($urandom_range(99) < rsp_stall_pct);

    always
    begin
        @(hold_off_ev);
        rsp_held = 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        rsp_held = 1'b0;
    end

    // Response checker: every accepted word against the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (pending_rsp_q.size() == 0)
                report_mismatch($sformatf("unexpected response max_key=%0d status=%0d count=%0d",
                                          max_key, status, count));
            else
            begin
                want_rsp = pending_rsp_q.pop_front();
                if (max_key !== want_rsp.max_key)
                    report_mismatch($sformatf("max_key %0d, want %0d",
                                              max_key, want_rsp.max_key));
                if (status !== want_rsp.status)
                    report_mismatch($sformatf("status %0d, want %0d",
                                              status, want_rsp.status));
                if (count !== want_rsp.count)
                    report_mismatch($sformatf("count %0d, want %0d",
                                              count, want_rsp.count));
            end
        end
    end

    // Watchdog: too long with no word moving on either channel means a hang.
    always @(posedge clk)
    begin
        if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("max_heap_priority_queue test failed");
            $finish;
        end
    end

    initial
    begin
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_no_idle();
        test_sender_idle();
        test_backpressure();
        test_fill_to_capacity();
        test_both_idle();

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("max_heap_priority_queue test passed");
        else
            $display("max_heap_priority_queue test failed");
        $finish;
    end

endmodule
